>>> rtl/uartrf_pkg.sv
// shared constants, types and the interrupt identification function of the uart register file
`timescale 1ns / 1ps
package uartrf_pkg;

   localparam int RX_FIFO_DEPTH = 16;
   localparam int BACKLOG_DEPTH = 256;
   localparam int RX_PTR_W = $clog2(RX_FIFO_DEPTH);
   localparam int RX_CNT_W = $clog2(RX_FIFO_DEPTH + 1);
   localparam int BL_PTR_W = $clog2(BACKLOG_DEPTH);
   localparam int BL_CNT_W = $clog2(BACKLOG_DEPTH + 1);

   // operation codes carried on tuser
   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_HOST  = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_OFFSET_SHIFT = 2'd0;
   localparam logic [1:0] CSR_HIGH_MARK    = 2'd1;
   localparam logic [1:0] CSR_LOW_MARK     = 2'd2;

   // register indexes after the offset shift
   localparam logic [5:0] REG_RBR = 6'd0;
   localparam logic [5:0] REG_IER = 6'd1;
   localparam logic [5:0] REG_IIR = 6'd2;
   localparam logic [5:0] REG_LCR = 6'd3;
   localparam logic [5:0] REG_MCR = 6'd4;
   localparam logic [5:0] REG_LSR = 6'd5;
   localparam logic [5:0] REG_MSR = 6'd6;
   localparam logic [5:0] REG_SCR = 6'd7;

   // commands from the controller to the datapath
   typedef struct packed {
      logic exec;
      logic pause_chk;
      logic refill_rd;
      logic refill_wr;
      logic fix;
      logic irq_eval;
      logic done;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic [1:0] op;
      logic       last;
      logic       refill_more;
      logic       out_free;
   } status_type;

   // prioritized interrupt identification value
   function automatic logic [7:0] iir_calc(
      input logic [7:0]          fcr,
      input logic [3:0]          ier,
      input logic [7:0]          lsr,
      input logic [7:0]          msr,
      input logic [RX_CNT_W-1:0] rx_count,
      input logic [3:0]          trig,
      input logic                timeout,
      input logic                thre
   );
      logic [7:0] base;
      logic       reached;
      logic [7:0] v;
      base    = fcr[0] ? 8'hC0 : 8'h00;
      reached = fcr[0] ? (rx_count >= RX_CNT_W'(trig)) : (rx_count != '0);
      if (ier[2] && (lsr & 8'h1E) != 8'h00)          v = base | 8'h06;
      else if (ier[0] && reached)                    v = base | 8'h04;
      else if (ier[0] && timeout)                    v = base | 8'h0C;
      else if (ier[1] && thre)                       v = base | 8'h02;
      else if (ier[3] && (msr & 8'h0F) != 8'h00)     v = base;
      else                                           v = base | 8'h01;
      return v;
   endfunction

endpackage

>>> rtl/uartrf_ctrl.sv
// sequencing state machine for one item of the uart register file
`timescale 1ns / 1ps
module uartrf_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  uartrf_pkg::status_type stat,
   output uartrf_pkg::cmd_type    cmd
);
   import uartrf_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EXEC = 3'd1;
   localparam logic [2:0] ST_PCHK = 3'd2;
   localparam logic [2:0] ST_RFRD = 3'd3;
   localparam logic [2:0] ST_RFWR = 3'd4;
   localparam logic [2:0] ST_FIX  = 3'd5;
   localparam logic [2:0] ST_IRQ  = 3'd6;
   localparam logic [2:0] ST_DONE = 3'd7;

   logic [2:0] state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            priority if (stat.op == OP_READ) state_in = ST_RFRD;
            else if (stat.op == OP_WRITE) state_in = ST_IRQ;
            else if (stat.op == OP_HOST && stat.last) state_in = ST_PCHK;
            else state_in = ST_DONE;
         end
         ST_PCHK: begin
            cmd.pause_chk = 1'b1;
            state_in      = ST_RFRD;
         end
         ST_RFRD: begin
            cmd.refill_rd = 1'b1;
            state_in      = stat.refill_more ? ST_RFWR : ST_FIX;
         end
         ST_RFWR: begin
            cmd.refill_wr = 1'b1;
            state_in      = ST_RFRD;
         end
         ST_FIX: begin
            cmd.fix  = 1'b1;
            state_in = ST_IRQ;
         end
         ST_IRQ: begin
            cmd.irq_eval = 1'b1;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            if (stat.out_free) begin
               cmd.done = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

>>> rtl/uartrf_dp.sv
// register file, receive fifo, backlog ring and result register of the uart
`timescale 1ns / 1ps
module uartrf_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_accept,
   input  logic [23:0]            req_tdata,
   input  logic [1:0]             req_tuser,
   input  logic                   req_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [23:0]            rsp_tdata,
   input  logic                   csr_accept,
   input  logic [1:0]             csr_index,
   input  logic [8:0]             csr_data,
   input  uartrf_pkg::cmd_type    cmd,
   output uartrf_pkg::status_type stat
);
   import uartrf_pkg::*;

   // configuration
   logic [1:0] shift_ff;
   logic [8:0] high_ff, low_ff;

   // captured item
   logic [1:0] op_ff;
   logic [5:0] idx_ff;
   logic [7:0] wd_ff, rb_ff;
   logic       last_ff;

   // uart registers
   logic [7:0] dll_ff, dll_in, dlm_ff, dlm_in, fcr_ff, fcr_in, lcr_ff, lcr_in;
   logic [7:0] lsr_ff, lsr_in, msr_ff, msr_in, scr_ff, scr_in;
   logic [3:0] ier_ff, ier_in, trig_ff, trig_in;
   logic [4:0] mcr_ff, mcr_in;
   logic       timeout_ff, timeout_in, thre_ff, thre_in, paused_ff, paused_in;
   logic       irq_ff, irq_in, moved_ff, moved_in;

   // receive fifo
   logic [7:0]          rx_mem [RX_FIFO_DEPTH];
   logic [RX_PTR_W-1:0] rx_wr_ff, rx_wr_in, rx_rd_ff, rx_rd_in;
   logic [RX_CNT_W-1:0] rx_cnt_ff, rx_cnt_in;
   logic                rx_we;
   logic [7:0]          rx_wdata;

   // backlog ring
   logic [7:0]          bl_mem [BACKLOG_DEPTH];
   logic [BL_PTR_W-1:0] bl_wr_ff, bl_wr_in, bl_rd_ff, bl_rd_in;
   logic [BL_CNT_W-1:0] bl_cnt_ff, bl_cnt_in;
   logic                bl_we;
   logic [7:0]          bl_q_ff;

   // per item results
   logic [7:0] rd_ff, rd_in, txb_ff, txb_in;
   logic       txv_ff, txv_in;
   logic       out_valid_ff;
   logic [23:0] out_ff;

   logic       dlab;
   logic [7:0] iir_now, wv, nw, delta;
   logic       rx_full;

   assign dlab    = lcr_ff[7];
   assign rx_full = (rx_cnt_ff >= RX_CNT_W'(RX_FIFO_DEPTH));
   assign iir_now = iir_calc(fcr_ff, ier_ff, lsr_ff, msr_ff, rx_cnt_ff, trig_ff,
                             timeout_ff, thre_ff);

   assign stat.op          = op_ff;
   assign stat.last        = last_ff;
   assign stat.refill_more = (bl_cnt_ff != '0) && !rx_full;
   assign stat.out_free    = !out_valid_ff || rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= 2'd0;
         high_ff  <= 9'd192;
         low_ff   <= 9'd64;
      end else if (csr_accept) begin
         unique case (csr_index)
            CSR_OFFSET_SHIFT: shift_ff <= csr_data[1:0];
            CSR_HIGH_MARK:    high_ff  <= csr_data;
            CSR_LOW_MARK:     low_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // item capture
   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff   <= req_tuser;
         idx_ff  <= req_tdata[5:0] >> shift_ff;
         wd_ff   <= req_tdata[13:6];
         rb_ff   <= req_tdata[21:14];
         last_ff <= req_tlast;
      end
   end

   // modem status after a modem control write
   always_comb begin
      nw = 8'h00;
      if (!wd_ff[4]) nw = 8'hB0;
      else begin
         if (wd_ff[0]) nw = nw | 8'h20;
         if (wd_ff[1]) nw = nw | 8'h10;
         if (wd_ff[2]) nw = nw | 8'h40;
         if (wd_ff[3]) nw = nw | 8'h80;
      end
      delta = ((msr_ff ^ nw) & 8'hB0) >> 4;
      if (msr_ff[6] && !nw[6]) delta = delta | 8'h04;
   end

   assign wv = wd_ff & 8'hCF;

   // register update for every command
   always_comb begin
      dll_in = dll_ff;  dlm_in = dlm_ff;  fcr_in = fcr_ff;  lcr_in = lcr_ff;
      lsr_in = lsr_ff;  msr_in = msr_ff;  scr_in = scr_ff;  ier_in = ier_ff;
      trig_in = trig_ff; mcr_in = mcr_ff; timeout_in = timeout_ff;
      thre_in = thre_ff; paused_in = paused_ff; irq_in = irq_ff; moved_in = moved_ff;
      rx_wr_in = rx_wr_ff; rx_rd_in = rx_rd_ff; rx_cnt_in = rx_cnt_ff;
      bl_wr_in = bl_wr_ff; bl_rd_in = bl_rd_ff; bl_cnt_in = bl_cnt_ff;
      rd_in = rd_ff; txb_in = txb_ff; txv_in = txv_ff;
      rx_we = 1'b0; rx_wdata = wd_ff; bl_we = 1'b0;

      if (cmd.exec) begin
         rd_in = 8'h00; txb_in = 8'h00; txv_in = 1'b0; moved_in = 1'b0;
         if (op_ff == OP_READ) begin
            unique case (idx_ff)
               REG_RBR: begin
                  if (dlab) rd_in = dll_ff;
                  else if (rx_cnt_ff != '0) begin
                     rd_in      = rx_mem[rx_rd_ff];
                     rx_rd_in   = (rx_rd_ff == RX_PTR_W'(RX_FIFO_DEPTH - 1)) ? '0
                                  : rx_rd_ff + 1'b1;
                     rx_cnt_in  = rx_cnt_ff - 1'b1;
                     timeout_in = 1'b0;
                     if (rx_cnt_ff == RX_CNT_W'(1)) lsr_in = lsr_ff & 8'hFE;
                  end
               end
               REG_IER: rd_in = dlab ? dlm_ff : {4'h0, ier_ff};
               REG_IIR: begin
                  rd_in = iir_now;
                  if ((iir_now & 8'h0E) == 8'h02) thre_in = 1'b0;
               end
               REG_LCR: rd_in = lcr_ff;
               REG_MCR: rd_in = {3'b000, mcr_ff};
               REG_LSR: begin
                  rd_in  = lsr_ff & 8'h7F;
                  lsr_in = lsr_ff & 8'hE1;
               end
               REG_MSR: begin
                  rd_in  = msr_ff;
                  msr_in = msr_ff & 8'hF0;
               end
               REG_SCR: rd_in = scr_ff;
               default: rd_in = 8'hFF;
            endcase
         end else if (op_ff == OP_WRITE) begin
            unique case (idx_ff)
               REG_RBR: begin
                  if (dlab) dll_in = wd_ff;
                  else if (mcr_ff[4]) begin
                     // loopback: transmitted byte lands in the receive fifo
                     if (rx_full) lsr_in = lsr_ff | 8'h02;
                     else begin
                        rx_we     = 1'b1;
                        rx_wr_in  = (rx_wr_ff == RX_PTR_W'(RX_FIFO_DEPTH - 1)) ? '0
                                    : rx_wr_ff + 1'b1;
                        rx_cnt_in = rx_cnt_ff + 1'b1;
                        lsr_in    = lsr_ff | 8'h01;
                     end
                  end else begin
                     txv_in  = 1'b1;
                     txb_in  = wd_ff;
                     lsr_in  = lsr_ff | 8'h60;
                     thre_in = 1'b1;
                  end
               end
               REG_IER: begin
                  if (dlab) dlm_in = wd_ff;
                  else begin
                     ier_in = wd_ff[3:0];
                     if (!ier_ff[1] && wd_ff[1]) thre_in = 1'b1;
                  end
               end
               REG_IIR: begin
                  if (!wv[0]) begin
                     fcr_in = 8'h00; trig_in = 4'd1;
                     rx_wr_in = '0; rx_rd_in = '0; rx_cnt_in = '0;
                     lsr_in = (lsr_ff & 8'hFC) | 8'h60;
                     thre_in = 1'b1;
                  end else begin
                     fcr_in = wv & 8'hC9;
                     if (wv[1]) begin
                        rx_wr_in = '0; rx_rd_in = '0; rx_cnt_in = '0;
                        lsr_in = lsr_ff & 8'hFC;
                     end
                     if (wv[2]) begin
                        lsr_in  = lsr_in | 8'h60;
                        thre_in = 1'b1;
                     end
                     unique case (wv[7:6])
                        2'b00:   trig_in = 4'd1;
                        2'b01:   trig_in = 4'd4;
                        2'b10:   trig_in = 4'd8;
                        default: trig_in = 4'd14;
                     endcase
                  end
               end
               REG_LCR: begin
                  lcr_in = wd_ff;
                  if (mcr_ff[4]) lsr_in = wd_ff[6] ? (lsr_ff | 8'h10) : (lsr_ff & 8'hEF);
               end
               REG_MCR: begin
                  mcr_in = wd_ff[4:0];
                  msr_in = nw | (msr_ff & 8'h0F) | delta;
               end
               REG_SCR: scr_in = wd_ff;
               default: ;
            endcase
         end else if (op_ff == OP_HOST) begin
            if (bl_cnt_ff >= BL_CNT_W'(BACKLOG_DEPTH)) lsr_in = lsr_ff | 8'h02;
            else begin
               bl_we     = 1'b1;
               bl_wr_in  = (bl_wr_ff == BL_PTR_W'(BACKLOG_DEPTH - 1)) ? '0
                           : bl_wr_ff + 1'b1;
               bl_cnt_in = bl_cnt_ff + 1'b1;
            end
         end
      end

      // pause check at the end of a host burst
      if (cmd.pause_chk) begin
         if (!paused_ff && bl_cnt_ff >= BL_CNT_W'(high_ff)) paused_in = 1'b1;
      end

      // move one backlog byte into the receive fifo
      if (cmd.refill_wr) begin
         rx_we     = 1'b1;
         rx_wdata  = bl_q_ff;
         rx_wr_in  = (rx_wr_ff == RX_PTR_W'(RX_FIFO_DEPTH - 1)) ? '0 : rx_wr_ff + 1'b1;
         rx_cnt_in = rx_cnt_ff + 1'b1;
         lsr_in    = lsr_ff | 8'h01;
         bl_rd_in  = (bl_rd_ff == BL_PTR_W'(BACKLOG_DEPTH - 1)) ? '0 : bl_rd_ff + 1'b1;
         bl_cnt_in = bl_cnt_ff - 1'b1;
         moved_in  = 1'b1;
      end

      // resume and timeout after a refill
      if (cmd.fix) begin
         if (paused_ff && bl_cnt_ff < BL_CNT_W'(low_ff)) paused_in = 1'b0;
         if (moved_ff)
            timeout_in = fcr_ff[0] && rx_cnt_ff != '0 && rx_cnt_ff < RX_CNT_W'(trig_ff);
      end

      if (cmd.irq_eval) irq_in = !iir_now[0];
   end

   // control and register state
   always_ff @(posedge clock) begin
      if (reset) begin
         dll_ff <= '0; dlm_ff <= '0; fcr_ff <= '0; lcr_ff <= '0;
         lsr_ff <= 8'h60; msr_ff <= 8'hB0; scr_ff <= '0; ier_ff <= '0;
         trig_ff <= '0; mcr_ff <= '0; timeout_ff <= 1'b0; thre_ff <= 1'b1;
         paused_ff <= 1'b0; irq_ff <= 1'b0; moved_ff <= 1'b0;
         rx_wr_ff <= '0; rx_rd_ff <= '0; rx_cnt_ff <= '0;
         bl_wr_ff <= '0; bl_rd_ff <= '0; bl_cnt_ff <= '0;
      end else begin
         dll_ff <= dll_in; dlm_ff <= dlm_in; fcr_ff <= fcr_in; lcr_ff <= lcr_in;
         lsr_ff <= lsr_in; msr_ff <= msr_in; scr_ff <= scr_in; ier_ff <= ier_in;
         trig_ff <= trig_in; mcr_ff <= mcr_in; timeout_ff <= timeout_in;
         thre_ff <= thre_in; paused_ff <= paused_in; irq_ff <= irq_in;
         moved_ff <= moved_in;
         rx_wr_ff <= rx_wr_in; rx_rd_ff <= rx_rd_in; rx_cnt_ff <= rx_cnt_in;
         bl_wr_ff <= bl_wr_in; bl_rd_ff <= bl_rd_in; bl_cnt_ff <= bl_cnt_in;
      end
   end

   // per item payload
   always_ff @(posedge clock) begin
      rd_ff  <= rd_in;
      txb_ff <= txb_in;
      txv_ff <= txv_in;
   end

   // receive fifo storage
   always_ff @(posedge clock) begin
      if (rx_we) rx_mem[rx_wr_ff] <= rx_wdata;
   end

   // backlog memory, registered read
   always_ff @(posedge clock) begin
      if (bl_we) bl_mem[bl_wr_ff] <= rb_ff;
      if (cmd.refill_rd) bl_q_ff <= bl_mem[bl_rd_ff];
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else if (cmd.done) out_valid_ff <= 1'b1;
      else if (rsp_tready) out_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.done) out_ff <= {5'b00000, paused_ff, txb_ff, txv_ff, irq_ff, rd_ff};
   end

endmodule

>>> rtl/uart_register_file_with_fifos_core.sv
// top level of the 16550a style uart register file with receive fifo and backlog
`timescale 1ns / 1ps
// One item is taken at a time and answered with one result. A bus write
// runs execute, interrupt evaluation and done; a host byte that does not
// end a burst, or an item with the unused opcode, runs execute and done. A
// bus read runs execute, the refill, fix, interrupt evaluation and done; a
// burst-ending host byte adds a pause check before the refill. Each byte
// that the refill moves from the backlog into the receive fifo (up to 16)
// takes a backlog memory read and then the fifo push. The next item is
// accepted after the result is loaded, even while it waits on rsp_tready;
// a waiting result holds the next one back. csr writes are always ready.
module uart_register_file_with_fifos_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // byte_offset[5:0], write_data[13:6], rx_byte[21:14]
   input  logic [1:0]  req_tuser,  // opcode[1:0]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // read_data[7:0], irq_level[8], tx_valid[9],
                                   // tx_byte[17:10], host_rx_paused[18]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [8:0]  csr_data
);
   import uartrf_pkg::*;

   cmd_type    cmd;
   status_type stat;

   assign csr_ready = 1'b1;

   // sequencer
   uartrf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // registers and storage
   uartrf_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_tvalid && req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_accept (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule

>>> rtl/uartrf_checker.sv
// port level checks for the uart register file core
`timescale 1ns / 1ps
module uartrf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   // a result stays offered until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped before it was taken");

   // one item in flight: no accept right after an accept
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item accepted while another is in work");

   // no transmit byte without transmit valid
   a_tx_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[9] |-> rsp_tdata[17:10] == 8'h00)
      else $error("tx byte set without tx valid");

   // a transmit comes from a write, which returns no read data
   a_tx_no_read: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[9] |-> rsp_tdata[7:0] == 8'h00)
      else $error("read data on a transmit item");

   // no result right after reset
   a_reset_clean: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind uart_register_file_with_fifos_core uartrf_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
